FILE: hdl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: hdl/phrf_pkg.sv
`default_nettype none

package phrf_pkg;

    localparam int NUM_RULES = 16;
    localparam int SLOT_W    = 4;
    localparam int ENA_W     = 12;

    localparam logic [1:0] CMD_CLASSIFY = 2'd0;
    localparam logic [1:0] CMD_WRITE    = 2'd1;
    localparam logic [1:0] CMD_CLEAR    = 2'd2;

    // packet or rule fields that travel down the chain
    typedef struct packed {
        logic [1:0]       cmd;
        logic [SLOT_W-1:0] slot;
        logic [47:0]      dst_mac;
        logic [47:0]      src_mac;
        logic [31:0]      src_ip;
        logic [31:0]      dst_ip;
        logic [7:0]       tos;
        logic [7:0]       ip_proto;
        logic [15:0]      eth_type;
        logic [15:0]      src_port;
        logic [15:0]      dst_port;
        logic [ENA_W-1:0] rule_enables;
    } item_t;

    // verdict carried along with the item
    typedef struct packed {
        logic              hit;
        logic              drop;
        logic [SLOT_W-1:0] hit_slot;
    } verdict_t;

endpackage

`default_nettype wire

FILE: hdl/phrf_cell.sv
`default_nettype none

// one rule slot; the item passes through every cycle the chain advances
module phrf_cell (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     advance,
    input  wire logic [phrf_pkg::SLOT_W-1:0] cell_idx,
    input  wire logic                     in_vld,
    input  wire phrf_pkg::item_t          in_item,
    input  wire phrf_pkg::verdict_t       in_verdict,
    output phrf_pkg::item_t               out_item,
    output phrf_pkg::verdict_t            out_verdict,
    output logic                          out_vld
);
    import phrf_pkg::*;

    logic     valid_reg;
    item_t    rule_reg;
    item_t    item_reg;
    verdict_t verdict_reg;
    verdict_t verdict_next;
    logic     vld_reg;
    logic     sel;
    logic     fields_ok;

    assign sel = (in_item.slot == cell_idx);

    always_comb begin
        fields_ok = 1'b1;
        if (rule_reg.rule_enables[0] && rule_reg.src_ip != in_item.src_ip) fields_ok = 1'b0;
        if (rule_reg.rule_enables[1] && rule_reg.dst_ip != in_item.dst_ip) fields_ok = 1'b0;
        if (rule_reg.rule_enables[2] && rule_reg.tos != in_item.tos) fields_ok = 1'b0;
        if (rule_reg.rule_enables[3] && rule_reg.ip_proto != in_item.ip_proto) fields_ok = 1'b0;
        if (rule_reg.rule_enables[4] && rule_reg.src_mac != in_item.src_mac) fields_ok = 1'b0;
        if (rule_reg.rule_enables[6] && rule_reg.eth_type != in_item.eth_type) fields_ok = 1'b0;
        if (rule_reg.rule_enables[8] && rule_reg.src_port != in_item.src_port) fields_ok = 1'b0;
        if (rule_reg.rule_enables[9] && rule_reg.dst_port != in_item.dst_port) fields_ok = 1'b0;
        if (rule_reg.rule_enables == '0) fields_ok = 1'b0;
        verdict_next = in_verdict;
        if (in_item.cmd == CMD_CLASSIFY && !in_verdict.hit && valid_reg &&
            rule_reg.dst_mac == in_item.dst_mac) begin
            verdict_next.hit      = 1'b1;
            verdict_next.drop     = fields_ok;
            verdict_next.hit_slot = cell_idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            vld_reg   <= 1'b0;
        end else if (advance) begin
            vld_reg <= in_vld;
            if (in_vld && sel && in_item.cmd == CMD_WRITE) valid_reg <= 1'b1;
            if (in_vld && sel && in_item.cmd == CMD_CLEAR) valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            item_reg    <= in_item;
            verdict_reg <= verdict_next;
            if (in_vld && sel && in_item.cmd == CMD_WRITE) rule_reg <= in_item;
        end
    end

    assign out_item    = item_reg;
    assign out_verdict = verdict_reg;
    assign out_vld     = vld_reg;
endmodule

`default_nettype wire

FILE: hdl/packet_header_rule_filter.sv
`default_nettype none

// Exact-match rule filter: sixteen rule cells in a row, one per slot. Each
// transaction enters the chain and moves one cell per cycle, passing every
// cell in slot order and then into the result register, while a new transaction
// can be taken every cycle; the chain halts only when the result port is stalled.
// Writes and clears update the addressed cell as they pass and return an
// all-zero result. The first matching valid cell sets the verdict.
module packet_header_rule_filter (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_cmd,
    input  wire logic [3:0]  s_slot,
    input  wire logic [47:0] s_dst_mac,
    input  wire logic [47:0] s_src_mac,
    input  wire logic [31:0] s_src_ip,
    input  wire logic [31:0] s_dst_ip,
    input  wire logic [7:0]  s_tos,
    input  wire logic [7:0]  s_ip_proto,
    input  wire logic [15:0] s_eth_type,
    input  wire logic [15:0] s_src_port,
    input  wire logic [15:0] s_dst_port,
    input  wire logic [11:0] s_rule_enables,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_drop,
    output logic             m_rule_hit,
    output logic [3:0]       m_hit_slot
);
    import phrf_pkg::*;

    item_t    items    [NUM_RULES+1];
    verdict_t verdicts [NUM_RULES+1];
    logic     vlds     [NUM_RULES+1];
    logic     advance;
    logic     out_vld_reg;
    verdict_t out_reg;

    // last cell's output moves to the result register when it is empty or being taken
    assign advance = !out_vld_reg || m_ready;
    assign s_ready = advance;

    assign items[0] = '{cmd: s_cmd, slot: s_slot, dst_mac: s_dst_mac, src_mac: s_src_mac,
                        src_ip: s_src_ip, dst_ip: s_dst_ip, tos: s_tos,
                        ip_proto: s_ip_proto, eth_type: s_eth_type,
                        src_port: s_src_port, dst_port: s_dst_port,
                        rule_enables: s_rule_enables};
    assign verdicts[0] = '0;
    assign vlds[0]     = s_valid;

    for (genvar i = 0; i < NUM_RULES; i++) begin : g_cell
        phrf_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .advance    (advance),
            .cell_idx   (SLOT_W'(i)),
            .in_vld     (vlds[i]),
            .in_item    (items[i]),
            .in_verdict (verdicts[i]),
            .out_item   (items[i+1]),
            .out_verdict(verdicts[i+1]),
            .out_vld    (vlds[i+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= vlds[NUM_RULES];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) out_reg <= verdicts[NUM_RULES];
    end

    assign m_valid    = out_vld_reg;
    assign m_drop     = out_reg.drop;
    assign m_rule_hit = out_reg.hit;
    assign m_hit_slot = out_reg.hit_slot;
endmodule

`default_nettype wire

FILE: hdl/phrf_checker.sv
`default_nettype none
`include "assert_macros.svh"

module phrf_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic       m_drop,
    input wire logic       m_rule_hit,
    input wire logic [3:0] m_hit_slot
);
    `ASSERT_IMPL(a_drop_needs_hit, aclk, aresetn, m_valid && m_drop, m_rule_hit)
    `ASSERT_IMPL(a_slot_zero_on_miss, aclk, aresetn, m_valid && !m_rule_hit, m_hit_slot == 4'd0)
    `ASSERT_IMPL(a_ready_when_out_free, aclk, aresetn, !m_valid, s_ready)
    `ASSERT_NEXT(a_out_holds, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_hit_slot))
endmodule

bind packet_header_rule_filter phrf_checker u_phrf_checker (.*);

`default_nettype wire
